// ----- src/swhc_pkg.sv -----
package swhc_pkg;

  // Bucket queue geometry
  localparam int BUCKET_DEPTH = 512;
  localparam int PTR_W        = $clog2(BUCKET_DEPTH);
  localparam int USED_W       = $clog2(BUCKET_DEPTH + 1);

  // Field widths
  localparam int TIME_W = 32;
  localparam int CNT_W  = 32;
  localparam int WIN_W  = 10;
  localparam int OUT_W  = 40;

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(300);
  localparam logic [CNT_W-1:0] SAT_MAX      = '1;

  // Item kinds carried on in_tuser
  localparam logic KIND_HIT   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CHECK = 3'b010,
    ST_APPLY = 3'b100
  } swhc_state_t;

  // Controller to datapath
  typedef struct packed {
    logic take;   // latch the accepted item
    logic evict;  // pop the oldest bucket
    logic apply;  // record the hit or post the query result
  } swhc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic stale;     // oldest bucket has left the window
    logic is_query;  // latched item is a query
    logic out_free;  // output register can take a result
  } swhc_stat_t;

endpackage

// ----- src/swhc_ctrl.sv -----
module swhc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  swhc_pkg::swhc_stat_t stat,
  output swhc_pkg::swhc_cmd_t  cmd
);
  import swhc_pkg::*;

  swhc_state_t state_r, state_nxt;

  // Sequence one item: take, evict stale buckets, apply
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.take  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.stale) begin
          cmd.evict = 1'b1;
        end else begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        // hold a query until the output register frees up
        if (!stat.is_query || stat.out_free) begin
          cmd.apply = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- src/swhc_dp.sv -----
module swhc_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_kind,
  input  logic [swhc_pkg::TIME_W-1:0] in_timestamp,
  input  logic                        cfg_valid,
  input  logic [swhc_pkg::WIN_W-1:0]  cfg_data,
  input  swhc_pkg::swhc_cmd_t         cmd,
  output swhc_pkg::swhc_stat_t        stat,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [swhc_pkg::CNT_W-1:0]  out_hit_total,
  output logic                        out_overflow
);
  import swhc_pkg::*;

  // Bucket memories
  logic [TIME_W-1:0] time_mem [BUCKET_DEPTH];
  logic [CNT_W-1:0]  cnt_mem  [BUCKET_DEPTH];

  logic [WIN_W-1:0]  window_r;
  logic              kind_r;
  logic [TIME_W-1:0] ts_r;
  logic [PTR_W-1:0]  oldest_ptr_r, oldest_ptr_nxt;
  logic [PTR_W-1:0]  newest_ptr_r;
  logic [USED_W-1:0] used_r;
  logic [CNT_W-1:0]  total_r;
  logic              overflow_r;
  logic [TIME_W-1:0] newest_time_r;
  logic [CNT_W-1:0]  newest_cnt_r;
  logic [TIME_W-1:0] rd_time_r;
  logic [CNT_W-1:0]  rd_cnt_r;
  logic              out_valid_r;
  logic [CNT_W-1:0]  out_total_r;
  logic              out_ovf_r;

  logic [PTR_W-1:0]  oldest_inc;
  logic [TIME_W:0]   limit;
  logic              stale;
  logic              same_bucket;
  logic              full;
  logic [USED_W:0]   tail_sum;
  logic [PTR_W-1:0]  tail_slot;
  logic [CNT_W-1:0]  total_inc;
  logic [CNT_W-1:0]  total_sub;
  logic              hit;
  logic              bump;
  logic              append;
  logic              drop;
  logic              query_load;
  logic              out_free;
  logic [PTR_W-1:0]  wr_cnt_addr;
  logic [CNT_W-1:0]  wr_cnt_data;

  // Queue pointer arithmetic
  assign oldest_inc = (oldest_ptr_r == PTR_W'(BUCKET_DEPTH - 1)) ? '0
                                                                 : oldest_ptr_r + 1'b1;
  assign oldest_ptr_nxt = cmd.evict ? oldest_inc : oldest_ptr_r;
  assign tail_sum  = (USED_W + 1)'(oldest_ptr_r) + (USED_W + 1)'(used_r);
  assign tail_slot = (tail_sum >= (USED_W + 1)'(BUCKET_DEPTH))
                   ? PTR_W'(tail_sum - (USED_W + 1)'(BUCKET_DEPTH))
                   : PTR_W'(tail_sum);

  // Window compare without wrap-around
  assign limit = (TIME_W + 1)'(rd_time_r) + (TIME_W + 1)'(window_r);
  assign stale = (used_r != '0) && (limit <= (TIME_W + 1)'(ts_r));

  assign same_bucket = (used_r != '0) && (newest_time_r == ts_r);
  assign full        = (used_r == USED_W'(BUCKET_DEPTH));

  // Saturating total updates
  assign total_inc = (total_r == SAT_MAX) ? total_r : total_r + 1'b1;
  assign total_sub = (total_r >= rd_cnt_r) ? total_r - rd_cnt_r : '0;

  assign hit        = cmd.apply && (kind_r == KIND_HIT);
  assign bump       = hit && same_bucket && (newest_cnt_r != SAT_MAX);
  assign append     = hit && !same_bucket && !full;
  assign drop       = hit && !same_bucket && full;
  assign query_load = cmd.apply && (kind_r == KIND_QUERY);
  assign out_free   = !out_valid_r || out_ready;

  assign wr_cnt_addr = bump ? newest_ptr_r : tail_slot;
  assign wr_cnt_data = bump ? newest_cnt_r + 1'b1 : CNT_W'(1);

  assign stat.stale    = stale;
  assign stat.is_query = (kind_r == KIND_QUERY);
  assign stat.out_free = out_free;

  // Write buckets, and register a read of the oldest one at the next pointer
  always_ff @(posedge clk) begin
    if (append) begin
      time_mem[tail_slot] <= ts_r;
    end
    if (bump || append) begin
      cnt_mem[wr_cnt_addr] <= wr_cnt_data;
    end
    rd_time_r <= time_mem[oldest_ptr_nxt];
    rd_cnt_r  <= cnt_mem[oldest_ptr_nxt];
  end

  // Latch item and newest bucket copy
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      kind_r <= in_kind;
      ts_r   <= in_timestamp;
    end
    if (append) begin
      newest_time_r <= ts_r;
      newest_cnt_r  <= CNT_W'(1);
    end else if (bump) begin
      newest_cnt_r <= wr_cnt_data;
    end
    if (query_load) begin
      out_total_r <= total_r;
      out_ovf_r   <= overflow_r;
    end
  end

  // Queue control state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r     <= WINDOW_RESET;
      oldest_ptr_r <= '0;
      newest_ptr_r <= '0;
      used_r       <= '0;
      total_r      <= '0;
      overflow_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        window_r <= cfg_data;
      end
      oldest_ptr_r <= oldest_ptr_nxt;
      if (cmd.evict) begin
        used_r  <= used_r - 1'b1;
        total_r <= total_sub;
      end else if (append) begin
        used_r       <= used_r + 1'b1;
        newest_ptr_r <= tail_slot;
        total_r      <= total_inc;
      end else if (bump) begin
        total_r <= total_inc;
      end
      if (drop) begin
        overflow_r <= 1'b1;
      end
      if (query_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_hit_total = out_total_r;
  assign out_overflow  = out_ovf_r;

endmodule

// ----- src/sliding_window_hit_counter.sv -----
// Channel  Dir  Handshake              Payload
// in_      in   in_tvalid/in_tready    tuser: kind; tdata: timestamp
// out_     out  out_tvalid/out_tready  tdata: hit_total, overflow
// cfg_     in   cfg_valid/cfg_ready    cfg_data: window_length
//
// An item goes through take, check and apply, staying in check while it evicts;
// eviction reads one bucket per cycle from the bucket memory's single read port.
// Synchronous active-low reset empties the queue, clears total and overflow
// and sets the window to 300. The memories are not cleared.
// A query result waits in the output register; a further query holds in_tready
// low until that register can take its result.
module sliding_window_hit_counter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [swhc_pkg::TIME_W-1:0] in_tdata,   // [31:0] timestamp
  input  logic                        in_tuser,   // [0] kind
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [swhc_pkg::OUT_W-1:0]  out_tdata,  // [31:0] hit_total, [32] overflow
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [swhc_pkg::WIN_W-1:0]  cfg_data    // [9:0] window_length
);
  import swhc_pkg::*;

  swhc_cmd_t         cmd;
  swhc_stat_t        stat;
  logic [CNT_W-1:0]  hit_total;
  logic              overflow;

  swhc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  swhc_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_kind       (in_tuser),
    .in_timestamp  (in_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_hit_total (hit_total),
    .out_overflow  (overflow)
  );

  assign cfg_ready = 1'b1;
  assign out_tdata = {(OUT_W - CNT_W - 1)'(0), overflow, hit_total};

endmodule

// ----- src/swhc_checker.sv -----
module swhc_assert (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [swhc_pkg::OUT_W-1:0]  out_tdata
);
  import swhc_pkg::*;

  // Block is busy in the cycle after it takes an item
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("in_tready high right after an item was taken");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  // Overflow flag never clears once reported
  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[CNT_W] |=> !out_tvalid || out_tdata[CNT_W])
    else $error("overflow flag cleared without reset");

  // Reset leaves an empty, ready block
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");

endmodule

bind sliding_window_hit_counter swhc_assert u_swhc_assert (.*);

// ----- tb/swhc_checker.sv -----
module swhc_checker
  import swhc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [TIME_W-1:0] in_tdata,   // [31:0] timestamp
  input  logic              in_tuser,   // [0] kind
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [OUT_W-1:0]  out_tdata,  // [31:0] hit_total, [32] overflow
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [WIN_W-1:0]  cfg_data,   // [9:0] window_length
  output int                fail_count,
  output int                owed
);

  // One query answer, laid out as on out_tdata
  typedef struct packed {
    logic             ovf;
    logic [CNT_W-1:0] hits;
  } tally_t;

  logic [TIME_W-1:0] slot_time  [BUCKET_DEPTH];
  logic [CNT_W-1:0]  slot_count [BUCKET_DEPTH];
  int unsigned       oldest;
  int unsigned       newest;
  int unsigned       live;
  logic [CNT_W-1:0]  total;
  logic              ovf_seen;
  logic [WIN_W-1:0]  win;
  tally_t            tally_q[$];

  // Drop buckets that have left the window, oldest first; the sum is 33 bits wide
  function automatic void age_out(logic [TIME_W-1:0] now);
    logic [TIME_W:0] reach;
    while (live > 0) begin
      reach = {1'b0, slot_time[oldest]} + (TIME_W+1)'(win);
      if (reach > {1'b0, now})
        break;
      total = (total >= slot_count[oldest]) ? total - slot_count[oldest] : '0;
      oldest = (oldest + 1) % BUCKET_DEPTH;
      live--;
    end
  endfunction

  // Bump the newest bucket or open a new one at the tail, flagging overflow when full
  function automatic void add_hit(logic [TIME_W-1:0] now);
    int unsigned slot;
    if (live > 0 && slot_time[newest] == now) begin
      if (slot_count[newest] == SAT_MAX)
        return;
      slot_count[newest]++;
    end else begin
      if (live >= BUCKET_DEPTH) begin
        ovf_seen = 1'b1;
        return;
      end
      slot = (oldest + live) % BUCKET_DEPTH;
      slot_time[slot]  = now;
      slot_count[slot] = 1;
      newest = slot;
      live++;
    end
    if (total != SAT_MAX)
      total++;
  endfunction

  // Track config writes, compare answers, predict on each accepted item
  always @(posedge clk) begin
    tally_t got;
    tally_t want;
    if (!rst_n) begin
      win        = WINDOW_RESET;
      oldest     = 0;
      newest     = 0;
      live       = 0;
      total      = '0;
      ovf_seen   = 1'b0;
      fail_count = 0;
      tally_q.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        win = cfg_data;
      if (out_tvalid && out_tready) begin
        got = tally_t'(out_tdata[CNT_W:0]);
        if (tally_q.size() == 0) begin
          $error("unexpected result: hit_total %0d overflow %0b", got.hits, got.ovf);
          fail_count++;
        end else begin
          want = tally_q.pop_front();
          if (got.hits !== want.hits) begin
            $error("hit_total: expected %0d, actual %0d", want.hits, got.hits);
            fail_count++;
          end
          if (got.ovf !== want.ovf) begin
            $error("overflow: expected %0b, actual %0b", want.ovf, got.ovf);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        age_out(in_tdata);
        if (in_tuser == KIND_QUERY)
          tally_q.push_back('{ovf: ovf_seen, hits: total});
        else
          add_hit(in_tdata);
      end
    end
    owed <= tally_q.size();
  end

endmodule

// ----- tb/tb.sv -----
module tb;
  import swhc_pkg::*;

  // Slowest run is roughly 1100 items plus drains; allow several times that
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = BUCKET_DEPTH + 16;
  localparam int SEGMENTS     = 8;
  localparam int SEG_ITEMS    = 55;
  localparam int HOLD_CYCLES  = 400;
  localparam logic [TIME_W-1:0] TIME_TOP = '1;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [TIME_W-1:0] in_tdata;
  logic              in_tuser;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [WIN_W-1:0]  cfg_data;
  int                fail_count;
  int                owed;

  int                cycle_count = 0;
  bit                no_idle     = 1'b0;
  bit                hold_req    = 1'b0;
  bit                hold_done   = 1'b0;
  logic [TIME_W-1:0] now;
  int                win_now;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sliding_window_hit_counter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  swhc_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .owed       (owed)
  );

  // Mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70)
      return $urandom_range(1, 2);
    if (r < 94)
      return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // Offer one item after an optional gap, hold it until accepted
  task automatic send(logic kind, logic [TIME_W-1:0] ts);
    int gap;
    gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= ts;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Wait for every owed answer, then let a full eviction run finish
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(int w);
    cfg_valid <= 1'b1;
    cfg_data  <= WIN_W'(w);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    win_now = w;
  endtask

  // Advance time in small steps mostly, with jumps back, far ahead and anywhere
  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60)
      now += $urandom_range(0, 2);
    else if (r < 85)
      now += $urandom_range(0, 2 * win_now + 2);
    else if (r < 92)
      now -= $urandom_range(0, win_now);
    else if (r < 97)
      now = $urandom;
    send(($urandom_range(0, 99) < 35) ? KIND_QUERY : KIND_HIT, now);
  endtask

  // Result side: random stalls, plus one long hold-off to back up the input
  initial begin : drain_side
    int stall_left;
    stall_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_done  = 1'b1;
        stall_left = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        stall_left = idle_len();
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    int seg_win [SEGMENTS];
    int w;
    logic [TIME_W-1:0] base;
    logic kind;
    seg_win = '{1, 512, 1023, 0, -1, -1, 64, 300};
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= KIND_HIT;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    win_now   = 300;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset window: empty query, same-time bumps, eviction at the exact edge
    send(KIND_QUERY, 0);
    send(KIND_HIT, 0);
    send(KIND_HIT, 0);
    send(KIND_HIT, 299);
    send(KIND_QUERY, 299);
    send(KIND_QUERY, 300);
    // Older hit goes behind a newer bucket and waits for it
    send(KIND_HIT, 298);
    send(KIND_QUERY, 300);
    send(KIND_QUERY, 599);
    // Near the top of the time range the window never wraps
    send(KIND_HIT, TIME_TOP - 255);
    send(KIND_HIT, TIME_TOP - 255);
    send(KIND_HIT, TIME_TOP);
    send(KIND_QUERY, TIME_TOP);
    send(KIND_QUERY, 0);
    // Zero window drops everything at or before the item time
    settle();
    write_window(0);
    send(KIND_QUERY, TIME_TOP);
    send(KIND_HIT, 10);
    send(KIND_QUERY, 10);

    // Random segments, one window setting each
    now = 0;
    for (int s = 0; s < SEGMENTS; s++) begin
      settle();
      w = (seg_win[s] < 0) ? $urandom_range(0, 1023) : seg_win[s];
      write_window(w);
      no_idle = (s % 4 == 3);
      if (s == 2)
        hold_req = 1'b1;
      for (int i = 0; i < SEG_ITEMS; i++)
        random_item();
    end

    // Empty the queue, then open more buckets than it holds
    settle();
    no_idle = 1'b0;
    write_window(0);
    send(KIND_QUERY, TIME_TOP);
    settle();
    write_window(1023);
    base = $urandom_range(0, 32'h7FFF_FFFF);
    now  = base;
    while (now - base < BUCKET_DEPTH + 8) begin
      kind = ($urandom_range(0, 15) == 0) ? KIND_QUERY : KIND_HIT;
      if (kind == KIND_HIT && $urandom_range(0, 9) != 0)
        now++;
      send(kind, now);
    end
    send(KIND_QUERY, now);
    // Evict a full queue in one pass
    send(KIND_QUERY, now + 1100);
    send(KIND_HIT, now + 1200);
    send(KIND_QUERY, now + 1200);
    settle();

    if (fail_count == 0 && owed == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule
